/* hdl/tpc_pkg.sv */
// shared constants, types and state codes for the three-point path curvature unit
package tpc_pkg;

  localparam int COORD_WIDTH = 32;
  localparam int CURV_WIDTH  = 32;

  localparam int LEN_SHIFT        = 16;
  localparam int CURV_SCALE_SHIFT = 61;

  localparam int PROD_W = 2 * COORD_WIDTH;
  localparam int SQ_W   = PROD_W + 1;
  localparam int RAD_W  = ((SQ_W + LEN_SHIFT + 1) / 2) * 2;
  localparam int ROOT_W = RAD_W / 2;
  localparam int REM_W  = ROOT_W + 2;
  localparam int AB_W   = 2 * ROOT_W;
  localparam int DEN_W  = 3 * ROOT_W;
  localparam int CM_W   = PROD_W + 1;
  localparam int XW     = PROD_W + 2;
  localparam int QW     = CURV_WIDTH - 1;
  localparam int DIV_SH = CURV_SCALE_SHIFT - QW;
  localparam int DV_W   = (DEN_W + 1 > CM_W + DIV_SH) ? DEN_W + 1 : CM_W + DIV_SH;
  localparam int SUM_W  = CURV_WIDTH + 2;
  localparam int D3_W   = ((CURV_WIDTH + 4) / 4) * 4;
  localparam int D3_STEPS = D3_W / 4;
  localparam int MUL_STEPS = 8;
  localparam int CNT_W  = $clog2((ROOT_W > QW ? ROOT_W : QW) + 1);

  localparam logic [1:0] PS_NONE = 2'd0;
  localparam logic [1:0] PS_ONE  = 2'd1;
  localparam logic [1:0] PS_TWO  = 2'd2;
  localparam logic [1:0] PS_FULL = 2'd3;

  localparam logic [1:0] K_FIRST = 2'd0;
  localparam logic [1:0] K_TAIL  = 2'd1;
  localparam logic [1:0] K_LAST  = 2'd2;

  localparam logic [1:0] SIDE_A = 2'd0;
  localparam logic [1:0] SIDE_B = 2'd1;
  localparam logic [1:0] SIDE_C = 2'd2;

  typedef struct packed {
    logic degen;
    logic sat;
  } flags_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIFF,
    ST_MUL,
    ST_SQRT,
    ST_CROSS,
    ST_DEN,
    ST_DIV,
    ST_RAW,
    ST_SUM,
    ST_DIV3,
    ST_OUT
  } state_t;

endpackage

/* hdl/tpc_in_if.sv */
// point input channel
interface tpc_in_if;
  logic                                    valid;
  logic                                    ready;
  logic signed [tpc_pkg::COORD_WIDTH-1:0]  point_x;
  logic signed [tpc_pkg::COORD_WIDTH-1:0]  point_y;
  logic                                    last_point;

  modport source (output valid, point_x, point_y, last_point, input ready);
  modport sink   (input valid, point_x, point_y, last_point, output ready);
endinterface

/* hdl/tpc_out_if.sv */
// curvature result channel
interface tpc_out_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [tpc_pkg::CURV_WIDTH-1:0]  curvature;
  logic                                   degenerate;
  logic                                   saturated;
  logic                                   last_of_path;

  modport source (output valid, curvature, degenerate, saturated, last_of_path, input ready);
  modport sink   (input valid, curvature, degenerate, saturated, last_of_path, output ready);
endinterface

/* hdl/three_point_path_curvature_unit.sv */
// Three-point path curvature unit: takes Q20.12 path points one beat at a time and returns
// the three-tap smoothed Menger curvature in Q8.24, two points behind the input. The first
// two points of a path are stored without a triangle computation. Every later point runs
// the triangle through one sequencer: the multiplier pass for the squared and cross terms,
// three square roots, a shift-add product a*b*c and a restoring divide, then a divide by
// three for each result beat, plus two flush beats on the final point. A triangle with a
// zero-length side skips the product and the divide. The unit takes no point while it works.
module three_point_path_curvature_unit (
  input  logic         clk,
  input  logic         rst_n,
  tpc_in_if.sink       in_ch,
  tpc_out_if.source    out_ch
);

  localparam int CW  = tpc_pkg::COORD_WIDTH;
  localparam int KW  = tpc_pkg::CURV_WIDTH;
  localparam int NW  = tpc_pkg::CNT_W;

  tpc_pkg::state_t state_r, state_nxt;
  logic [NW-1:0]   cnt_r;

  logic signed [CW-1:0] px_r, py_r, ox_r, oy_r, nx_r, ny_r;
  logic                 last_r, short_r;
  logic [1:0]           ps_r, k_r, side_r;

  logic signed [KW-1:0] oraw_r, nraw_r, rraw_r;
  tpc_pkg::flags_t      oflg_r, nflg_r, rflg_r;

  logic [CW-1:0] adx_r, ady_r, bdx_r, bdy_r, cdx_r, cdy_r;
  logic          sax_r, say_r, sbx_r, sby_r, dgn_r;

  logic [tpc_pkg::SQ_W-1:0]   rad0_r, rad1_r, rad2_r;
  logic [tpc_pkg::PROD_W-1:0] m1_r, m2_r;

  logic [tpc_pkg::RAD_W-1:0]  rad_sh_r;
  logic [tpc_pkg::REM_W-1:0]  sq_rem_r;
  logic [tpc_pkg::ROOT_W-1:0] root_r, a_r, b_r, c_r;

  logic                       neg_r, pass_r, sat_r;
  logic [tpc_pkg::AB_W-1:0]   mcand_r;
  logic [tpc_pkg::ROOT_W-1:0] mplier_r;
  logic [tpc_pkg::DEN_W-1:0]  acc_r;
  logic [tpc_pkg::DV_W-1:0]   dv_rem_r;
  logic [tpc_pkg::QW-1:0]     q_r;

  logic [tpc_pkg::D3_W-1:0]   d3_sh_r, q3_r;
  logic [1:0]                 rem3_r;
  logic                       sneg_r;
  tpc_pkg::flags_t            resflg_r;
  logic                       reslast_r;

  logic                 out_valid_r, out_last_r;
  logic signed [KW-1:0] out_curv_r;
  tpc_pkg::flags_t      out_flg_r;

  logic in_acc, load_out, done, cnt_wrap;

  // multiplier operands
  logic [CW-1:0]               mul_a, mul_b;
  logic [tpc_pkg::PROD_W-1:0]  prod;

  always_comb begin
    case (cnt_r[2:0])
      3'd0:    begin mul_a = adx_r; mul_b = adx_r; end
      3'd1:    begin mul_a = ady_r; mul_b = ady_r; end
      3'd2:    begin mul_a = bdx_r; mul_b = bdx_r; end
      3'd3:    begin mul_a = bdy_r; mul_b = bdy_r; end
      3'd4:    begin mul_a = cdx_r; mul_b = cdx_r; end
      3'd5:    begin mul_a = cdy_r; mul_b = cdy_r; end
      3'd6:    begin mul_a = adx_r; mul_b = bdy_r; end
      default: begin mul_a = ady_r; mul_b = bdx_r; end
    endcase
    prod = mul_a * mul_b;
  end

  // point differences
  function automatic logic [CW:0] sdiff(input logic signed [CW-1:0] p,
                                         input logic signed [CW-1:0] q);
    logic signed [CW:0] d;
    d = {p[CW-1], p} - {q[CW-1], q};
    return d;
  endfunction

  function automatic logic [CW-1:0] dmag(input logic [CW:0] d);
    logic [CW:0] m;
    m = d[CW] ? -d : d;
    return m[CW-1:0];
  endfunction

  logic [CW:0] dx1, dy1, dx2, dy2, dx3, dy3;
  always_comb begin
    dx1 = sdiff(nx_r, ox_r);
    dy1 = sdiff(ny_r, oy_r);
    dx2 = sdiff(px_r, nx_r);
    dy2 = sdiff(py_r, ny_r);
    dx3 = sdiff(ox_r, px_r);
    dy3 = sdiff(oy_r, py_r);
  end

  // square root step, two radicand bits per cycle
  logic [tpc_pkg::REM_W+1:0]  sq_t, sq_trial;
  logic                       sq_ge;
  logic [tpc_pkg::REM_W-1:0]  sq_rem_nxt;
  logic [tpc_pkg::ROOT_W-1:0] root_nxt;
  logic [tpc_pkg::SQ_W-1:0]   rad_next_side;

  always_comb begin
    sq_t       = {sq_rem_r, rad_sh_r[tpc_pkg::RAD_W-1 -: 2]};
    sq_trial   = (tpc_pkg::REM_W + 2)'({root_r, 2'b01});
    sq_ge      = sq_t >= sq_trial;
    sq_rem_nxt = sq_ge ? tpc_pkg::REM_W'(sq_t - sq_trial) : tpc_pkg::REM_W'(sq_t);
    root_nxt   = {root_r[tpc_pkg::ROOT_W-2:0], sq_ge};
    rad_next_side = (side_r == tpc_pkg::SIDE_A) ? rad1_r : rad2_r;
  end

  // signed cross product
  logic signed [tpc_pkg::XW-1:0] t1, t2, xprod;
  logic [tpc_pkg::CM_W-1:0]      cm_val;
  always_comb begin
    t1 = (sax_r ^ sby_r) ? -$signed(tpc_pkg::XW'(m1_r)) : $signed(tpc_pkg::XW'(m1_r));
    t2 = (say_r ^ sbx_r) ? -$signed(tpc_pkg::XW'(m2_r)) : $signed(tpc_pkg::XW'(m2_r));
    xprod  = t1 - t2;
    cm_val = xprod[tpc_pkg::XW-1] ? tpc_pkg::CM_W'(-xprod) : tpc_pkg::CM_W'(xprod);
  end

  // shift-add product and restoring divide
  logic [tpc_pkg::DEN_W-1:0] acc_nxt;
  logic [tpc_pkg::DV_W-1:0]  den_ext, dv_t;
  logic                      dv_ge0, dv_ge;
  always_comb begin
    acc_nxt = (acc_r << 1) +
              (mplier_r[tpc_pkg::ROOT_W-1] ? tpc_pkg::DEN_W'(mcand_r) : '0);
    den_ext = tpc_pkg::DV_W'(acc_r);
    dv_ge0  = dv_rem_r >= den_ext;
    dv_t    = dv_rem_r << 1;
    dv_ge   = dv_t >= den_ext;
  end

  // raw value with sign and clipping
  logic [KW-1:0]        lim, qmag;
  logic signed [KW-1:0] raw_val;
  always_comb begin
    lim     = {1'b0, {tpc_pkg::QW{1'b1}}};
    qmag    = sat_r ? lim : {1'b0, q_r};
    raw_val = neg_r ? -$signed(qmag) : $signed(qmag);
  end

  // three-tap sum for the current result beat
  logic signed [KW-1:0]          su, sv, sw;
  tpc_pkg::flags_t               fu, fv, fw, sflg;
  logic signed [tpc_pkg::SUM_W-1:0] sum;
  logic                          slast;
  always_comb begin
    su = nraw_r; sv = nraw_r; sw = nraw_r;
    fu = nflg_r; fv = nflg_r; fw = nflg_r;
    slast = 1'b0;
    case (k_r)
      tpc_pkg::K_FIRST: begin
        su = ps_r == tpc_pkg::PS_TWO ? rraw_r : oraw_r;
        fu = ps_r == tpc_pkg::PS_TWO ? rflg_r : oflg_r;
        sv = ps_r == tpc_pkg::PS_TWO ? rraw_r : nraw_r;
        fv = ps_r == tpc_pkg::PS_TWO ? rflg_r : nflg_r;
        sw = rraw_r;
        fw = rflg_r;
      end
      tpc_pkg::K_TAIL: begin
        su = oraw_r;
        fu = oflg_r;
      end
      default: begin
        slast = 1'b1;
      end
    endcase
    sum  = tpc_pkg::SUM_W'(su) + tpc_pkg::SUM_W'(sv) + tpc_pkg::SUM_W'(sw);
    sflg = fu | fv | fw;
    if (short_r) begin
      sum  = '0;
      sflg = '{degen: 1'b1, sat: 1'b0};
    end
  end

  // divide by three, four bits per cycle
  logic [2:0] d3_t;
  logic [1:0] d3_rem;
  logic [3:0] d3_q;
  always_comb begin
    d3_rem = rem3_r;
    d3_q = '0;
    for (int j = 0; j < 4; j++) begin
      d3_t = {d3_rem, d3_sh_r[tpc_pkg::D3_W-1-j]};
      if (d3_t >= 3'd3) begin
        d3_q[3-j] = 1'b1;
        d3_rem    = 2'(d3_t - 3'd3);
      end else begin
        d3_rem = d3_t[1:0];
      end
    end
  end

  logic signed [KW-1:0] res_val;
  assign res_val = sneg_r ? -$signed(q3_r[KW-1:0]) : $signed(q3_r[KW-1:0]);

  // handshake outputs
  always_comb begin
    in_ch.ready = state_r == tpc_pkg::ST_IDLE;
    in_acc      = in_ch.valid && in_ch.ready;
    load_out    = state_r == tpc_pkg::ST_OUT && (!out_valid_r || out_ch.ready);
    done        = k_r == tpc_pkg::K_LAST || (k_r == tpc_pkg::K_FIRST && !last_r);
  end

  // step counter restarts for each root and each product pass
  assign cnt_wrap = (state_r == tpc_pkg::ST_SQRT || state_r == tpc_pkg::ST_DEN) &&
                    cnt_r == NW'(tpc_pkg::ROOT_W - 1);

  assign out_ch.valid        = out_valid_r;
  assign out_ch.curvature    = out_curv_r;
  assign out_ch.degenerate   = out_flg_r.degen;
  assign out_ch.saturated    = out_flg_r.sat;
  assign out_ch.last_of_path = out_last_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      tpc_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (ps_r[1])               state_nxt = tpc_pkg::ST_DIFF;
          else if (in_ch.last_point) state_nxt = tpc_pkg::ST_SUM;
        end
      end
      tpc_pkg::ST_DIFF:  state_nxt = tpc_pkg::ST_MUL;
      tpc_pkg::ST_MUL: begin
        if (cnt_r == NW'(tpc_pkg::MUL_STEPS - 1)) state_nxt = tpc_pkg::ST_SQRT;
      end
      tpc_pkg::ST_SQRT: begin
        if (cnt_r == NW'(tpc_pkg::ROOT_W - 1) && side_r == tpc_pkg::SIDE_C)
          state_nxt = tpc_pkg::ST_CROSS;
      end
      tpc_pkg::ST_CROSS: state_nxt = dgn_r ? tpc_pkg::ST_SUM : tpc_pkg::ST_DEN;
      tpc_pkg::ST_DEN: begin
        if (cnt_r == NW'(tpc_pkg::ROOT_W - 1) && pass_r) state_nxt = tpc_pkg::ST_DIV;
      end
      tpc_pkg::ST_DIV: begin
        if ((cnt_r == '0 && dv_ge0) || cnt_r == NW'(tpc_pkg::QW))
          state_nxt = tpc_pkg::ST_RAW;
      end
      tpc_pkg::ST_RAW:   state_nxt = tpc_pkg::ST_SUM;
      tpc_pkg::ST_SUM:   state_nxt = tpc_pkg::ST_DIV3;
      tpc_pkg::ST_DIV3: begin
        if (cnt_r == NW'(tpc_pkg::D3_STEPS - 1)) state_nxt = tpc_pkg::ST_OUT;
      end
      tpc_pkg::ST_OUT: begin
        if (load_out) state_nxt = done ? tpc_pkg::ST_IDLE : tpc_pkg::ST_SUM;
      end
      default:           state_nxt = tpc_pkg::ST_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tpc_pkg::ST_IDLE;
      cnt_r       <= '0;
      ps_r        <= tpc_pkg::PS_NONE;
      k_r         <= tpc_pkg::K_FIRST;
      side_r      <= tpc_pkg::SIDE_A;
      pass_r      <= 1'b0;
      short_r     <= 1'b0;
      out_valid_r <= 1'b0;
      ox_r <= '0; oy_r <= '0; nx_r <= '0; ny_r <= '0;
      oraw_r <= '0; nraw_r <= '0;
      oflg_r <= '0; nflg_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_nxt != state_r || cnt_wrap) cnt_r <= '0;
      else                                  cnt_r <= cnt_r + 1'b1;

      if (load_out)          out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;

      case (state_r)
        tpc_pkg::ST_IDLE: begin
          if (in_acc) begin
            short_r <= !ps_r[1];
            if (!ps_r[1] && in_ch.last_point)
              k_r <= (ps_r == tpc_pkg::PS_ONE) ? tpc_pkg::K_TAIL : tpc_pkg::K_LAST;
            else
              k_r <= tpc_pkg::K_FIRST;
            if (!ps_r[1]) begin
              ox_r <= nx_r; oy_r <= ny_r;
              nx_r <= in_ch.point_x; ny_r <= in_ch.point_y;
              if (!in_ch.last_point) ps_r <= ps_r + 1'b1;
            end
          end
        end
        tpc_pkg::ST_MUL: side_r <= tpc_pkg::SIDE_A;
        tpc_pkg::ST_SQRT: begin
          if (cnt_r == NW'(tpc_pkg::ROOT_W - 1)) side_r <= side_r + 1'b1;
        end
        tpc_pkg::ST_CROSS: pass_r <= 1'b0;
        tpc_pkg::ST_DEN: begin
          if (cnt_r == NW'(tpc_pkg::ROOT_W - 1)) pass_r <= 1'b1;
        end
        tpc_pkg::ST_SUM: begin
          if (k_r == tpc_pkg::K_FIRST && !short_r) begin
            oraw_r <= ps_r == tpc_pkg::PS_TWO ? rraw_r : nraw_r;
            oflg_r <= ps_r == tpc_pkg::PS_TWO ? rflg_r : nflg_r;
            nraw_r <= rraw_r;
            nflg_r <= rflg_r;
            ox_r <= nx_r; oy_r <= ny_r;
            nx_r <= px_r; ny_r <= py_r;
            ps_r <= tpc_pkg::PS_FULL;
          end
        end
        tpc_pkg::ST_OUT: begin
          if (load_out) begin
            k_r <= k_r + 1'b1;
            if (k_r == tpc_pkg::K_LAST) begin
              ps_r <= tpc_pkg::PS_NONE;
              ox_r <= '0; oy_r <= '0; nx_r <= '0; ny_r <= '0;
              oraw_r <= '0; nraw_r <= '0;
              oflg_r <= '0; nflg_r <= '0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state_r)
      tpc_pkg::ST_IDLE: begin
        if (in_acc) begin
          px_r   <= in_ch.point_x;
          py_r   <= in_ch.point_y;
          last_r <= in_ch.last_point;
        end
      end
      tpc_pkg::ST_DIFF: begin
        adx_r <= dmag(dx1); ady_r <= dmag(dy1);
        bdx_r <= dmag(dx2); bdy_r <= dmag(dy2);
        cdx_r <= dmag(dx3); cdy_r <= dmag(dy3);
        sax_r <= dx1[CW];   say_r <= dy1[CW];
        sbx_r <= dx2[CW];   sby_r <= dy2[CW];
        dgn_r <= (dx1 == '0 && dy1 == '0) || (dx2 == '0 && dy2 == '0) ||
                 (dx3 == '0 && dy3 == '0);
      end
      tpc_pkg::ST_MUL: begin
        case (cnt_r[2:0])
          3'd0:    rad0_r <= tpc_pkg::SQ_W'(prod);
          3'd1:    rad0_r <= rad0_r + tpc_pkg::SQ_W'(prod);
          3'd2:    rad1_r <= tpc_pkg::SQ_W'(prod);
          3'd3:    rad1_r <= rad1_r + tpc_pkg::SQ_W'(prod);
          3'd4:    rad2_r <= tpc_pkg::SQ_W'(prod);
          3'd5:    rad2_r <= rad2_r + tpc_pkg::SQ_W'(prod);
          3'd6:    m1_r   <= prod;
          default: m2_r   <= prod;
        endcase
        rad_sh_r <= tpc_pkg::RAD_W'({rad0_r, {tpc_pkg::LEN_SHIFT{1'b0}}});
        sq_rem_r <= '0;
        root_r   <= '0;
      end
      tpc_pkg::ST_SQRT: begin
        if (cnt_r == NW'(tpc_pkg::ROOT_W - 1)) begin
          case (side_r)
            tpc_pkg::SIDE_A: a_r <= root_nxt;
            tpc_pkg::SIDE_B: b_r <= root_nxt;
            default:         c_r <= root_nxt;
          endcase
          rad_sh_r <= tpc_pkg::RAD_W'({rad_next_side, {tpc_pkg::LEN_SHIFT{1'b0}}});
          sq_rem_r <= '0;
          root_r   <= '0;
        end else begin
          rad_sh_r <= rad_sh_r << 2;
          sq_rem_r <= sq_rem_nxt;
          root_r   <= root_nxt;
        end
      end
      tpc_pkg::ST_CROSS: begin
        neg_r    <= xprod[tpc_pkg::XW-1];
        dv_rem_r <= tpc_pkg::DV_W'(cm_val) << tpc_pkg::DIV_SH;
        mcand_r  <= tpc_pkg::AB_W'(a_r);
        mplier_r <= b_r;
        acc_r    <= '0;
        q_r      <= '0;
        sat_r    <= 1'b0;
        if (dgn_r) begin
          rraw_r <= '0;
          rflg_r <= '{degen: 1'b1, sat: 1'b0};
        end
      end
      tpc_pkg::ST_DEN: begin
        if (cnt_r == NW'(tpc_pkg::ROOT_W - 1) && !pass_r) begin
          mcand_r  <= acc_nxt[tpc_pkg::AB_W-1:0];
          mplier_r <= c_r;
          acc_r    <= '0;
        end else begin
          acc_r    <= acc_nxt;
          mplier_r <= mplier_r << 1;
        end
      end
      tpc_pkg::ST_DIV: begin
        if (cnt_r == '0) begin
          sat_r <= dv_ge0;
        end else begin
          dv_rem_r <= dv_ge ? dv_t - den_ext : dv_t;
          q_r      <= {q_r[tpc_pkg::QW-2:0], dv_ge};
        end
      end
      tpc_pkg::ST_RAW: begin
        rraw_r <= raw_val;
        rflg_r <= '{degen: 1'b0, sat: sat_r};
      end
      tpc_pkg::ST_SUM: begin
        sneg_r    <= sum[tpc_pkg::SUM_W-1];
        d3_sh_r   <= tpc_pkg::D3_W'(sum[tpc_pkg::SUM_W-1] ? -sum : sum);
        q3_r      <= '0;
        rem3_r    <= '0;
        resflg_r  <= sflg;
        reslast_r <= slast;
      end
      tpc_pkg::ST_DIV3: begin
        d3_sh_r <= d3_sh_r << 4;
        q3_r    <= {q3_r[tpc_pkg::D3_W-5:0], d3_q};
        rem3_r  <= d3_rem;
      end
      tpc_pkg::ST_OUT: begin
        if (load_out) begin
          out_curv_r <= res_val;
          out_flg_r  <= resflg_r;
          out_last_r <= reslast_r;
        end
      end
      default: ;
    endcase
  end

endmodule

/* hdl/tpc_chk.sv */
// port-level checker for the three-point path curvature unit
module tpc_chk (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_valid,
  input logic                                in_ready,
  input logic                                in_last_point,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic signed [tpc_pkg::CURV_WIDTH-1:0] out_curvature
);

  // a stalled result beat stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_curvature))
    else $error("stalled result changed");

  // the final point always starts the flush
  a_last_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_last_point |=> !in_ready)
    else $error("input taken again right after final point");

  // results are only loaded while the unit is busy
  a_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result appeared while idle");

endmodule

bind three_point_path_curvature_unit tpc_chk u_tpc_chk (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .in_last_point (in_ch.last_point),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_curvature (out_ch.curvature)
);
